FILE: rtl/core/nsg_pkg.sv
// Shared widths, constants and saturating scale functions for the smooth number generator.
`timescale 1ns / 1ps

package nsg_pkg;

    localparam int VALUE_W       = 40;
    localparam int INDEX_W       = 12;
    localparam int MAX_N_DEFAULT = 2048;

    localparam logic [VALUE_W-1:0] VALUE_MAX = {VALUE_W{1'b1}};
    localparam logic [VALUE_W-1:0] VALUE_ONE = VALUE_W'(1);

    // Products carry three guard bits; any of them set means the value saturates.
    function automatic logic [VALUE_W-1:0] f_sat(input logic [VALUE_W+2:0] p);
        return (p[VALUE_W+2:VALUE_W] != 3'b000) ? VALUE_MAX : p[VALUE_W-1:0];
    endfunction

    function automatic logic [VALUE_W-1:0] f_times2(input logic [VALUE_W-1:0] v);
        return f_sat({2'b00, v, 1'b0});
    endfunction

    function automatic logic [VALUE_W-1:0] f_times3(input logic [VALUE_W-1:0] v);
        return f_sat({3'b000, v} + {2'b00, v, 1'b0});
    endfunction

    function automatic logic [VALUE_W-1:0] f_times5(input logic [VALUE_W-1:0] v);
        return f_sat({3'b000, v} + {1'b0, v, 2'b00});
    endfunction

endpackage

FILE: rtl/core/nsg_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
`timescale 1ns / 1ps

module nsg_ram #(
    parameter int WIDTH = 40,
    parameter int DEPTH = 2048,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: rtl/core/nsg_ctrl.sv
// Sequencer that extends the sequence store by a three-way merge and answers queries.
`timescale 1ns / 1ps

module nsg_ctrl #(
    parameter int MAX_N = nsg_pkg::MAX_N_DEFAULT,
    parameter int AW    = (MAX_N > 1) ? $clog2(MAX_N) : 1,
    parameter int FW    = $clog2(MAX_N + 1)
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  logic [FW-1:0]               i_n,
    input  logic                        i_clamp,
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output logic [nsg_pkg::VALUE_W-1:0] o_smooth_value,
    output logic                        o_index_clamped,
    output logic                        o_we,
    output logic [AW-1:0]               o_waddr,
    output logic [nsg_pkg::VALUE_W-1:0] o_wdata,
    output logic [AW-1:0]               o_addr_a,
    output logic [AW-1:0]               o_addr_b,
    input  logic [nsg_pkg::VALUE_W-1:0] i_rdata_a,
    input  logic [nsg_pkg::VALUE_W-1:0] i_rdata_b
);
    import nsg_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_INIT,
        S_MERGE,
        S_LOAD,
        S_ANSWER
    } t_state;

    t_state             r_state;
    logic [FW-1:0]      r_n;
    logic               r_clamp;
    logic [FW-1:0]      r_fill;
    logic [AW-1:0]      r_ptr2;
    logic [AW-1:0]      r_ptr3;
    logic [AW-1:0]      r_ptr5;
    logic [VALUE_W-1:0] r_c2;
    logic [VALUE_W-1:0] r_c3;
    logic [VALUE_W-1:0] r_c5;
    logic [VALUE_W-1:0] r_last;
    logic [2:0]         r_pend;
    logic               r_fwd_a;
    logic               r_fwd_b;
    logic               r_out_valid;
    logic [VALUE_W-1:0] r_out_value;
    logic               r_out_clamp;

    logic [VALUE_W-1:0] w_next;
    logic               w_a2;
    logic               w_a3;
    logic               w_a5;
    logic [AW-1:0]      w_p2n;
    logic [AW-1:0]      w_p3n;
    logic [AW-1:0]      w_p5n;
    logic [AW-1:0]      w_pbn;
    logic [AW-1:0]      w_fill_addr;
    logic [FW-1:0]      w_n_minus1;
    logic               w_grow;
    logic               w_out_free;
    logic [VALUE_W-1:0] w_src_a;
    logic [VALUE_W-1:0] w_src_b;

    always_comb begin
        w_next = r_c2;
        if (r_c3 < w_next) begin
            w_next = r_c3;
        end
        if (r_c5 < w_next) begin
            w_next = r_c5;
        end
    end

    assign w_a2        = (r_c2 == w_next);
    assign w_a3        = (r_c3 == w_next);
    assign w_a5        = (r_c5 == w_next);
    assign w_p2n       = r_ptr2 + AW'(1);
    assign w_p3n       = r_ptr3 + AW'(1);
    assign w_p5n       = r_ptr5 + AW'(1);
    // Port B serves the times-three pointer first; times-five is read after it if both move.
    assign w_pbn       = w_a3 ? w_p3n : w_p5n;
    assign w_fill_addr = r_fill[AW-1:0];
    assign w_n_minus1  = r_n - FW'(1);
    assign w_grow      = (r_state == S_MERGE) && (r_fill < r_n);
    assign w_out_free  = !r_out_valid || !i_out_stall;
    // A refetch that hit the entry written in the same cycle takes the written value.
    assign w_src_a     = r_fwd_a ? r_last : i_rdata_a;
    assign w_src_b     = r_fwd_b ? r_last : i_rdata_b;

    always_comb begin
        o_we     = 1'b0;
        o_waddr  = w_fill_addr;
        o_wdata  = w_next;
        o_addr_a = w_p2n;
        o_addr_b = r_ptr5;
        unique case (r_state)
            S_INIT: begin
                o_we    = 1'b1;
                o_waddr = '0;
                o_wdata = VALUE_ONE;
            end
            S_MERGE: begin
                o_we     = w_grow;
                o_addr_a = w_grow ? w_p2n : w_n_minus1[AW-1:0];
                o_addr_b = w_pbn;
            end
            S_ANSWER: begin
                o_addr_a = w_n_minus1[AW-1:0];
            end
            S_IDLE, S_LOAD: begin
                o_addr_b = r_ptr5;
            end
            default: begin
                o_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_fill      <= '0;
            r_ptr2      <= '0;
            r_ptr3      <= '0;
            r_ptr5      <= '0;
            r_pend      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            // The answer state reloads the output register itself.
            if (r_out_valid && !i_out_stall && (r_state != S_ANSWER)) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_n     <= i_n;
                        r_clamp <= i_clamp;
                        r_state <= (r_fill == '0) ? S_INIT : S_MERGE;
                    end
                end
                S_INIT: begin
                    r_fill  <= FW'(1);
                    r_c2    <= f_times2(VALUE_ONE);
                    r_c3    <= f_times3(VALUE_ONE);
                    r_c5    <= f_times5(VALUE_ONE);
                    r_state <= S_MERGE;
                end
                S_MERGE: begin
                    if (w_grow) begin
                        r_fill  <= r_fill + FW'(1);
                        r_last  <= w_next;
                        r_pend  <= {w_a2, w_a3, w_a5};
                        r_fwd_a <= (w_p2n == w_fill_addr);
                        r_fwd_b <= (w_pbn == w_fill_addr);
                        if (w_a2) begin
                            r_ptr2 <= w_p2n;
                        end
                        if (w_a3) begin
                            r_ptr3 <= w_p3n;
                        end
                        if (w_a5) begin
                            r_ptr5 <= w_p5n;
                        end
                        r_state <= S_LOAD;
                    end else begin
                        r_state <= S_ANSWER;
                    end
                end
                S_LOAD: begin
                    if (r_pend[2]) begin
                        r_c2 <= f_times2(w_src_a);
                    end
                    if (r_pend[1]) begin
                        r_c3 <= f_times3(w_src_b);
                    end else if (r_pend[0]) begin
                        r_c5 <= f_times5(w_src_b);
                    end
                    if (r_pend[1] && r_pend[0]) begin
                        r_pend  <= 3'b001;
                        r_fwd_b <= 1'b0;
                        r_state <= S_LOAD;
                    end else begin
                        r_state <= S_MERGE;
                    end
                end
                S_ANSWER: begin
                    if (w_out_free) begin
                        r_out_valid <= 1'b1;
                        r_out_value <= i_rdata_a;
                        r_out_clamp <= r_clamp;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_in_stall      = (r_state != S_IDLE);
    assign o_out_valid     = r_out_valid;
    assign o_smooth_value  = r_out_value;
    assign o_index_clamped = r_out_clamp;

endmodule

FILE: rtl/core/nth_smooth_number_generator.sv
// A query for an entry already generated passes the idle, merge and answer states, and the
// answer state registers the result; a first query on an empty store also passes the init state.
// Each new entry the query must add takes a merge step and a load step, and a second load step
// when the times-three and times-five pointers move together, as for each entry divisible by 15.
// Throughput: one query at a time; the next transfer is taken once the result is registered.
// Reset clears the pointers, the fill count and the output valid; the store is not cleared.
`timescale 1ns / 1ps

// Top level of the 5-smooth number generator.
//
// The sequence store holds the smooth numbers in ascending order and persists across
// queries. A query only extends the store as far as the requested index and then reads
// that entry. Each extension step takes the smallest of three candidates, held scaled in
// registers: the entry under each of the three pointers times 2, 3 and 5. Every pointer
// whose candidate equals the new entry advances, and its new entry is read back from the
// store and scaled. The store is kept in two identical RAM copies written together, so
// that two pointers can be refetched in the same cycle; the memory read ports set the
// step rate.
module nth_smooth_number_generator #(
    parameter int MAX_N = nsg_pkg::MAX_N_DEFAULT
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  logic [nsg_pkg::INDEX_W-1:0] i_target_index,
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output logic [nsg_pkg::VALUE_W-1:0] o_smooth_value,
    output logic                        o_index_clamped
);
    import nsg_pkg::*;

    localparam int AW    = (MAX_N > 1) ? $clog2(MAX_N) : 1;
    localparam int FW    = $clog2(MAX_N + 1);
    localparam int EXT_W = INDEX_W + 1;

    logic [EXT_W-1:0]   w_index_ext;
    logic               w_zero;
    logic               w_high;
    logic [EXT_W-1:0]   w_n_ext;
    logic [FW-1:0]      w_n;
    logic               w_we;
    logic [AW-1:0]      w_waddr;
    logic [VALUE_W-1:0] w_wdata;
    logic [AW-1:0]      w_addr_a;
    logic [AW-1:0]      w_addr_b;
    logic [VALUE_W-1:0] w_rdata_a;
    logic [VALUE_W-1:0] w_rdata_b;

    // An index of zero becomes one and an index past the store becomes MAX_N; both are flagged.
    assign w_index_ext = EXT_W'(i_target_index);
    assign w_zero      = (i_target_index == '0);
    assign w_high      = (w_index_ext > EXT_W'(MAX_N));
    assign w_n_ext     = w_zero ? EXT_W'(1) : (w_high ? EXT_W'(MAX_N) : w_index_ext);
    assign w_n         = FW'(w_n_ext);

    nsg_ctrl #(
        .MAX_N (MAX_N),
        .AW    (AW),
        .FW    (FW)
    ) u_ctrl (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_n             (w_n),
        .i_clamp         (w_zero || w_high),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_smooth_value  (o_smooth_value),
        .o_index_clamped (o_index_clamped),
        .o_we            (w_we),
        .o_waddr         (w_waddr),
        .o_wdata         (w_wdata),
        .o_addr_a        (w_addr_a),
        .o_addr_b        (w_addr_b),
        .i_rdata_a       (w_rdata_a),
        .i_rdata_b       (w_rdata_b)
    );

    // Copy A serves the times-two pointer and the answer read.
    nsg_ram #(
        .WIDTH (VALUE_W),
        .DEPTH (MAX_N),
        .AW    (AW)
    ) u_store_a (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_addr_a),
        .o_rdata (w_rdata_a)
    );

    // Copy B serves the times-three and times-five pointers.
    nsg_ram #(
        .WIDTH (VALUE_W),
        .DEPTH (MAX_N),
        .AW    (AW)
    ) u_store_b (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_addr_b),
        .o_rdata (w_rdata_b)
    );

endmodule

FILE: rtl/core/nsg_checker.sv
// Port-level checks for the smooth number generator and their bind to the top level.
`timescale 1ns / 1ps

module nsg_checker (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        i_in_valid,
    input logic                        o_in_stall,
    input logic [nsg_pkg::INDEX_W-1:0] i_target_index,
    input logic                        o_out_valid,
    input logic                        i_out_stall,
    input logic [nsg_pkg::VALUE_W-1:0] o_smooth_value,
    input logic                        o_index_clamped
);

    // A result waiting on a stalled receiver keeps its value.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_smooth_value)
            && $stable(o_index_clamped))
        else $error("stalled result changed");

    // The block works on one query at a time, so a transfer makes it busy next cycle.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("input taken again right after a transfer");

    // Every smooth number is at least one.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_smooth_value != '0)
        else $error("smooth value of zero");

    // Reset leaves no result pending.
    assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

endmodule

bind nth_smooth_number_generator nsg_checker u_nsg_checker (.*);
